// File: rtl/rgbfs_pkg.sv
// ----------------------------------------------------------------------------
// rgbfs_pkg
// Shared types and constants of the rgb mode and fade sequencer.
// ----------------------------------------------------------------------------
package rgbfs_pkg;

   localparam int DUTY_BITS_DEFAULT = 8;
   localparam int LEVEL_W           = 8;
   localparam int MODE_W            = 4;
   localparam int PHASE_W           = 3;

   localparam logic [LEVEL_W-1:0] BRIGHTNESS_RESET = 8'd50;
   localparam logic [LEVEL_W-1:0] RAMP_LIMIT       = 8'd255;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_FADE   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_RED    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_GREEN  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_BLUE   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_YELLOW = 4'd5;
   localparam logic [MODE_W-1:0] MODE_PURPLE = 4'd6;
   localparam logic [MODE_W-1:0] MODE_CYAN   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_OFF    = 4'd8;

   // fade phase codes
   localparam logic [PHASE_W-1:0] PH_BLUE_UP1   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_GREEN_UP   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_BLUE_DOWN  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RED_UP     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_GREEN_DOWN = 3'd4;
   localparam logic [PHASE_W-1:0] PH_BLUE_UP2   = 3'd5;
   localparam logic [PHASE_W-1:0] PH_BR_DOWN    = 3'd6;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PHASE_W-1:0] phase;
      logic [LEVEL_W-1:0] ramp;
      logic               restart;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      mode:    MODE_FADE,
      phase:   PH_BLUE_UP1,
      ramp:    '0,
      restart: 1'b1,
      red:     '0,
      green:   '0,
      blue:    '0
   };

endpackage

// File: rtl/rgbfs_step.sv
// ----------------------------------------------------------------------------
// rgbfs_step
// Next-state logic for one transaction: mode stepping, static colors and
// one count of the fade ramp.
// ----------------------------------------------------------------------------
module rgbfs_step #(
   parameter int DUTY_BITS = rgbfs_pkg::DUTY_BITS_DEFAULT
) (
   input  rgbfs_pkg::seq_state_type cur_state,
   input  logic [7:0]               brightness,
   input  logic                     key_next,
   input  logic                     key_prev,
   input  logic                     tick_elapsed,
   output rgbfs_pkg::seq_state_type nxt_state
);
   import rgbfs_pkg::*;

   localparam logic [31:0] DutyMax = (32'd1 << DUTY_BITS) - 32'd1;

   logic [LEVEL_W-1:0] peak;
   logic [MODE_W-1:0]  mode;
   logic [LEVEL_W-1:0] cnt_base;
   logic [LEVEL_W-1:0] up;
   logic [LEVEL_W-1:0] down;
   seq_state_type      fade;

   // brightness saturates at the duty range
   assign peak = ({24'd0, brightness} > DutyMax) ? DutyMax[LEVEL_W-1:0] : brightness;

   always_comb begin
      if (key_next) begin
         mode = (cur_state.mode >= MODE_OFF) ? MODE_FADE : cur_state.mode + 4'd1;
      end else if (key_prev) begin
         mode = (cur_state.mode <= MODE_FADE) ? MODE_OFF : cur_state.mode - 4'd1;
      end else begin
         mode = cur_state.mode;
      end
   end

   // one ramp count of the fade
   assign cnt_base = cur_state.restart ? '0 : cur_state.ramp;
   assign up       = (cnt_base < RAMP_LIMIT) ? cnt_base + 8'd1 : cnt_base;
   assign down     = (peak > up) ? peak - up : '0;

   always_comb begin
      fade         = cur_state;
      fade.mode    = mode;
      fade.ramp    = up;
      fade.restart = 1'b0;
      case (cur_state.phase)
         PH_BLUE_UP1:   fade.blue  = up;
         PH_GREEN_UP:   fade.green = up;
         PH_BLUE_DOWN:  fade.blue  = down;
         PH_RED_UP:     fade.red   = up;
         PH_GREEN_DOWN: fade.green = down;
         PH_BLUE_UP2:   fade.blue  = up;
         default: begin
            fade.blue = down;
            fade.red  = down;
         end
      endcase
      if (up >= peak) begin
         fade.phase   = (cur_state.phase >= PH_BR_DOWN) ? PH_BLUE_UP1
                                                        : cur_state.phase + 3'd1;
         fade.restart = 1'b1;
      end
   end

   always_comb begin
      nxt_state      = cur_state;
      nxt_state.mode = mode;
      case (mode)
         MODE_FADE: begin
            if (peak == '0) begin
               nxt_state.red   = '0;
               nxt_state.green = '0;
               nxt_state.blue  = '0;
            end else if (tick_elapsed) begin
               nxt_state = fade;
            end
         end
         MODE_RED: begin
            nxt_state.red   = peak;
            nxt_state.green = '0;
            nxt_state.blue  = '0;
         end
         MODE_GREEN: begin
            nxt_state.red   = '0;
            nxt_state.green = peak;
            nxt_state.blue  = '0;
         end
         MODE_BLUE: begin
            nxt_state.red   = '0;
            nxt_state.green = '0;
            nxt_state.blue  = peak;
         end
         MODE_YELLOW: begin
            nxt_state.red   = peak;
            nxt_state.green = peak;
            nxt_state.blue  = '0;
         end
         MODE_PURPLE: begin
            nxt_state.red   = peak;
            nxt_state.green = '0;
            nxt_state.blue  = peak;
         end
         MODE_CYAN: begin
            nxt_state.red   = '0;
            nxt_state.green = peak;
            nxt_state.blue  = peak;
         end
         default: begin
            nxt_state.red   = '0;
            nxt_state.green = '0;
            nxt_state.blue  = '0;
         end
      endcase
   end

endmodule

// File: rtl/rgb_mode_and_fade_sequencer_top.sv
// ----------------------------------------------------------------------------
// rgb_mode_and_fade_sequencer_top
// Rgb led mode selector with static colors and a seven-phase fade.
// ----------------------------------------------------------------------------
// Each request transaction (next/prev key flags and a tick flag) gives one
// response transaction with the three duty values and the mode number after
// the update. A request is taken every cycle while the input register is empty
// or the response register is free; it passes an input register and, when
// the response side is not stalled, reaches the response register. The input
// register lets a new request in while a response waits to be taken. The user
// must write the brightness register (reset 50) through the csr port only while
// no request is in flight (not enforced); the step saturates it to DUTY_BITS.
module rgb_mode_and_fade_sequencer_top #(
   parameter int DUTY_BITS = rgbfs_pkg::DUTY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_key_next,
   input  logic       req_key_prev,
   input  logic       req_tick_elapsed,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_duty,
   output logic [7:0] rsp_green_duty,
   output logic [7:0] rsp_blue_duty,
   output logic [3:0] rsp_mode_number,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);
   import rgbfs_pkg::*;

   logic          in_valid_ff;
   logic          in_key_next_ff;
   logic          in_key_prev_ff;
   logic          in_tick_ff;
   logic          out_valid_ff;
   logic [7:0]    brightness_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic          out_free;
   logic          advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;

   rgbfs_step #(
      .DUTY_BITS (DUTY_BITS)
   ) u_step (
      .cur_state    (state_ff),
      .brightness   (brightness_ff),
      .key_next     (in_key_next_ff),
      .key_prev     (in_key_prev_ff),
      .tick_elapsed (in_tick_ff),
      .nxt_state    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         brightness_ff <= BRIGHTNESS_RESET;
         state_ff      <= SEQ_STATE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            brightness_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_key_next_ff <= req_key_next;
         in_key_prev_ff <= req_key_prev;
         in_tick_ff     <= req_tick_elapsed;
      end
   end

   // the response shows the sequencer state after the last transaction
   assign rsp_valid       = out_valid_ff;
   assign rsp_red_duty    = state_ff.red;
   assign rsp_green_duty  = state_ff.green;
   assign rsp_blue_duty   = state_ff.blue;
   assign rsp_mode_number = state_ff.mode;

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode >= MODE_FADE && state_ff.mode <= MODE_OFF)
      else $error("mode number out of range");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_BR_DOWN)
      else $error("fade phase out of range");

   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_number == MODE_OFF |->
         rsp_red_duty == '0 && rsp_green_duty == '0 && rsp_blue_duty == '0)
      else $error("off mode drives a nonzero duty");

   a_red_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_number == MODE_RED |->
         rsp_green_duty == '0 && rsp_blue_duty == '0)
      else $error("red mode drives green or blue");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

endmodule
